>>> rtl/psd_pkg.sv
`default_nettype none

package psd_pkg;

    // Coordinate width. The fraction width (8 bits) does not enter the
    // arithmetic: the distance comes out in the same units as the inputs.
    localparam int COORD_BITS = 24;

    localparam int DW   = COORD_BITS + 1;         // coordinate differences, signed
    localparam int PW   = 2 * DW;                 // products of differences, signed
    localparam int SQW  = 2 * COORD_BITS + 2;     // sums of squares, unsigned
    localparam int C1W  = 2 * COORD_BITS + 3;     // v.w, signed
    localparam int XW   = 2 * COORD_BITS + 2;     // cross product components, signed
    localparam int XMW  = 2 * COORD_BITS + 1;     // cross component magnitude
    localparam int HW   = COORD_BITS + 1;         // low half of a split magnitude
    localparam int HHW  = 2 * COORD_BITS;         // hi*hi partial product
    localparam int HLW  = 2 * COORD_BITS + 1;     // hi*lo partial product
    localparam int LLW  = 2 * COORD_BITS + 2;     // lo*lo partial product
    localparam int NUMW = 4 * COORD_BITS + 4;     // |v x w|^2
    localparam int QW   = 2 * COORD_BITS + 2;     // quotient, squared distance
    localparam int REMW = SQW + 1;                // divider partial remainder
    localparam int RW   = COORD_BITS + 1;         // square root, distance
    localparam int SRW  = RW + 2;                 // square root remainder

    localparam logic [1:0] MODE_CLAMP  = 2'd0;
    localparam logic [1:0] MODE_STRICT = 2'd1;
    localparam logic [1:0] MODE_INCL   = 2'd2;

    localparam logic [1:0] REGION_INSIDE = 2'd0;
    localparam logic [1:0] REGION_BEFORE = 2'd1;
    localparam logic [1:0] REGION_PAST   = 2'd2;

    typedef struct packed {
        logic [1:0]                   mode;
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] point_z;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] start_z;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic signed [COORD_BITS-1:0] end_z;
    } in_t;

    typedef struct packed {
        logic [COORD_BITS:0] dist_res;
        logic [1:0]          region;
        logic                outside;
    } out_t;

    typedef struct packed {
        logic [1:0] region;
        logic       outside;
    } side_t;

    typedef struct packed {
        logic            valid;
        side_t           side;
        logic [QW-1:0]   low;
        logic [REMW-1:0] rem;
        logic [SQW-1:0]  den;
        logic [QW-1:0]   quo;
    } div_t;

    typedef struct packed {
        logic           valid;
        side_t          side;
        logic [QW-1:0]  rad;
        logic [SRW-1:0] rem;
        logic [RW-1:0]  root;
    } sqrt_t;

endpackage

`default_nettype wire

>>> rtl/psd_front.sv
`default_nettype none

module psd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          item_valid,
    input  psd_pkg::in_t  item,
    output psd_pkg::div_t q
);
    import psd_pkg::*;

    // Stage 1: differences.
    logic                 s1_valid_reg;
    logic [1:0]           s1_mode_reg, s1_mode_next;
    logic signed [DW-1:0] s1_v_reg [3];
    logic signed [DW-1:0] s1_w_reg [3];
    logic signed [DW-1:0] s1_u_reg [3];
    logic signed [DW-1:0] s1_v_next [3];
    logic signed [DW-1:0] s1_w_next [3];
    logic signed [DW-1:0] s1_u_next [3];

    // Stage 2: products.
    logic                 s2_valid_reg;
    logic [1:0]           s2_mode_reg;
    logic signed [PW-1:0] s2_vw_reg [3];
    logic signed [PW-1:0] s2_vv_reg [3];
    logic signed [PW-1:0] s2_ww_reg [3];
    logic signed [PW-1:0] s2_uu_reg [3];
    logic signed [PW-1:0] s2_xa_reg [3];
    logic signed [PW-1:0] s2_xb_reg [3];

    // Stage 3: dot products and cross product.
    logic                  s3_valid_reg;
    logic [1:0]            s3_mode_reg;
    logic signed [C1W-1:0] s3_c1_reg;
    logic [SQW-1:0]        s3_c2_reg, s3_ww_reg, s3_uu_reg;
    logic signed [XW-1:0]  s3_x_reg [3];

    // Stage 4: region and split squares.
    logic                 s4_valid_reg;
    side_t                s4_side_reg, s4_side_next;
    logic [SQW-1:0]       s4_c2_reg, s4_ww_reg, s4_uu_reg;
    logic [HHW-1:0]       s4_hh_reg [3];
    logic [HLW-1:0]       s4_hl_reg [3];
    logic [LLW-1:0]       s4_ll_reg [3];
    logic [XW-1:0]        s4_mag [3];
    logic [HW-1:0]        s4_lo [3];
    logic [XMW-HW-1:0]    s4_hi [3];
    logic                 s4_before, s4_past;

    // Stage 5: numerator and divider operands.
    logic                 s5_valid_reg;
    div_t                 s5_data_reg, s5_data_next;
    logic [NUMW-1:0]      s5_num;
    logic [SQW-1:0]       s5_target;

    always_comb
    begin
        s1_mode_next = (item.mode == MODE_STRICT || item.mode == MODE_INCL) ?
                       item.mode : MODE_CLAMP;
        s1_v_next[0] = DW'(item.end_x) - DW'(item.start_x);
        s1_v_next[1] = DW'(item.end_y) - DW'(item.start_y);
        s1_v_next[2] = DW'(item.end_z) - DW'(item.start_z);
        s1_w_next[0] = DW'(item.point_x) - DW'(item.start_x);
        s1_w_next[1] = DW'(item.point_y) - DW'(item.start_y);
        s1_w_next[2] = DW'(item.point_z) - DW'(item.start_z);
        s1_u_next[0] = DW'(item.point_x) - DW'(item.end_x);
        s1_u_next[1] = DW'(item.point_y) - DW'(item.end_y);
        s1_u_next[2] = DW'(item.point_z) - DW'(item.end_z);
    end

    always_comb
    begin
        s4_before = (s3_mode_reg == MODE_STRICT) ? (s3_c1_reg < 0) : (s3_c1_reg <= 0);
        s4_past   = $signed({1'b0, s3_c2_reg}) <= s3_c1_reg;
        s4_side_next.region  = s4_before ? REGION_BEFORE :
                               (s4_past ? REGION_PAST : REGION_INSIDE);
        s4_side_next.outside = (s3_mode_reg != MODE_CLAMP) && (s4_before || s4_past);
        for (int i = 0; i < 3; i++)
        begin
            s4_mag[i] = (s3_x_reg[i] < 0) ? XW'(-s3_x_reg[i]) : XW'(s3_x_reg[i]);
            s4_lo[i]  = s4_mag[i][HW-1:0];
            s4_hi[i]  = s4_mag[i][XMW-1:HW];
        end
    end

    always_comb
    begin
        s5_num = '0;
        for (int i = 0; i < 3; i++)
        begin
            s5_num = s5_num + (NUMW'(s4_hh_reg[i]) << (2 * HW))
                            + (NUMW'(s4_hl_reg[i]) << (HW + 1))
                            + NUMW'(s4_ll_reg[i]);
        end
        s5_target = (s4_side_reg.region == REGION_BEFORE) ? s4_ww_reg : s4_uu_reg;
        s5_data_next.valid = 1'b1;
        s5_data_next.side  = s4_side_reg;
        s5_data_next.quo   = '0;
        if (s4_side_reg.region == REGION_INSIDE)
        begin
            s5_data_next.low = s5_num[QW-1:0];
            s5_data_next.rem = REMW'(s5_num[NUMW-1:QW]);
            s5_data_next.den = s4_c2_reg;
        end
        else
        begin
            // Endpoint distance: divide the squared length by one.
            s5_data_next.low = QW'(s5_target);
            s5_data_next.rem = '0;
            s5_data_next.den = SQW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= item_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mode_reg <= s1_mode_next;
            s1_v_reg    <= s1_v_next;
            s1_w_reg    <= s1_w_next;
            s1_u_reg    <= s1_u_next;

            s2_mode_reg <= s1_mode_reg;
            for (int i = 0; i < 3; i++)
            begin
                s2_vw_reg[i] <= PW'(s1_v_reg[i]) * PW'(s1_w_reg[i]);
                s2_vv_reg[i] <= PW'(s1_v_reg[i]) * PW'(s1_v_reg[i]);
                s2_ww_reg[i] <= PW'(s1_w_reg[i]) * PW'(s1_w_reg[i]);
                s2_uu_reg[i] <= PW'(s1_u_reg[i]) * PW'(s1_u_reg[i]);
            end
            s2_xa_reg[0] <= PW'(s1_v_reg[1]) * PW'(s1_w_reg[2]);
            s2_xb_reg[0] <= PW'(s1_v_reg[2]) * PW'(s1_w_reg[1]);
            s2_xa_reg[1] <= PW'(s1_v_reg[2]) * PW'(s1_w_reg[0]);
            s2_xb_reg[1] <= PW'(s1_v_reg[0]) * PW'(s1_w_reg[2]);
            s2_xa_reg[2] <= PW'(s1_v_reg[0]) * PW'(s1_w_reg[1]);
            s2_xb_reg[2] <= PW'(s1_v_reg[1]) * PW'(s1_w_reg[0]);

            s3_mode_reg <= s2_mode_reg;
            s3_c1_reg   <= C1W'(s2_vw_reg[0]) + C1W'(s2_vw_reg[1]) + C1W'(s2_vw_reg[2]);
            s3_c2_reg   <= SQW'($unsigned(s2_vv_reg[0])) + SQW'($unsigned(s2_vv_reg[1]))
                         + SQW'($unsigned(s2_vv_reg[2]));
            s3_ww_reg   <= SQW'($unsigned(s2_ww_reg[0])) + SQW'($unsigned(s2_ww_reg[1]))
                         + SQW'($unsigned(s2_ww_reg[2]));
            s3_uu_reg   <= SQW'($unsigned(s2_uu_reg[0])) + SQW'($unsigned(s2_uu_reg[1]))
                         + SQW'($unsigned(s2_uu_reg[2]));
            for (int i = 0; i < 3; i++)
            begin
                s3_x_reg[i] <= XW'(s2_xa_reg[i]) - XW'(s2_xb_reg[i]);
            end

            s4_side_reg <= s4_side_next;
            s4_c2_reg   <= s3_c2_reg;
            s4_ww_reg   <= s3_ww_reg;
            s4_uu_reg   <= s3_uu_reg;
            for (int i = 0; i < 3; i++)
            begin
                s4_hh_reg[i] <= HHW'(s4_hi[i]) * HHW'(s4_hi[i]);
                s4_hl_reg[i] <= HLW'(s4_hi[i]) * HLW'(s4_lo[i]);
                s4_ll_reg[i] <= LLW'(s4_lo[i]) * LLW'(s4_lo[i]);
            end

            s5_data_reg <= s5_data_next;
        end
    end

    always_comb
    begin
        q       = s5_data_reg;
        q.valid = s5_valid_reg;
    end

endmodule

`default_nettype wire

>>> rtl/psd_div_cell.sv
`default_nettype none

// One restoring division step: brings down one dividend bit and settles
// one quotient bit.
module psd_div_cell #(
    parameter int STEP = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  psd_pkg::div_t d,
    output psd_pkg::div_t q
);
    import psd_pkg::*;

    logic            valid_reg;
    div_t            data_reg, data_next;
    logic [REMW-1:0] trial;
    logic [REMW-1:0] den_ext;

    always_comb
    begin
        trial     = {d.rem[REMW-2:0], d.low[STEP]};
        den_ext   = REMW'(d.den);
        data_next = d;
        if (trial >= den_ext)
        begin
            data_next.rem       = trial - den_ext;
            data_next.quo[STEP] = 1'b1;
        end
        else
        begin
            data_next.rem = trial;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= d.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        q       = data_reg;
        q.valid = valid_reg;
    end

endmodule

`default_nettype wire

>>> rtl/psd_sqrt_cell.sv
`default_nettype none

// One digit-by-digit square root step: takes two radicand bits and
// settles one root bit.
module psd_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  psd_pkg::sqrt_t d,
    output psd_pkg::sqrt_t q
);
    import psd_pkg::*;

    localparam int TW = SRW + 2;

    logic          valid_reg;
    sqrt_t         data_reg, data_next;
    logic [TW-1:0] acc;
    logic [TW-1:0] trial;
    logic          take;

    always_comb
    begin
        acc   = {d.rem, d.rad[2*STEP+1 -: 2]};
        trial = TW'({d.root, 2'b01});
        take  = acc >= trial;
        data_next      = d;
        data_next.root = {d.root[RW-2:0], take};
        data_next.rem  = take ? SRW'(acc - trial) : acc[SRW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= d.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        q       = data_reg;
        q.valid = valid_reg;
    end

endmodule

`default_nettype wire

>>> rtl/point_segment_distance_3d_core.sv
`default_nettype none

// Distance from a 3D point to a line segment, fully pipelined. Each input
// word carries a mode, a point and the segment's two ends in signed fixed
// point; each output word carries the floor of the exact distance in the
// same units, the region of the projection (inside, before the start, past
// the end) and an outside flag. In mode 0 a projection outside the segment
// gives the distance to the nearer endpoint; in modes 1 and 2 it is flagged
// and the distance reads all ones. The block takes one word per clock while
// the receiver does not stall the output, and holds no state between words.
// It has five front stages for differences, products, dot and cross
// products, region and split squares, and numerator and divider operands,
// then a row of 2*COORD_BITS+2 divider cells (one quotient bit each), a row
// of COORD_BITS+1 square root cells (one root bit each) and the output
// register. The whole row advances together; it freezes only while the
// output register holds a word that the receiver stalls.
module point_segment_distance_3d_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  psd_pkg::in_t  item,
    output logic          result_valid,
    input  logic          result_stall,
    output psd_pkg::out_t result
);
    import psd_pkg::*;

    logic  en;
    logic  result_valid_reg;
    out_t  result_reg, result_next;
    div_t  dchain [QW+1];
    sqrt_t schain [RW+1];

    // Everything moves unless a finished word sits in the output register
    // and is being held off.
    assign en         = !result_valid_reg || !result_stall;
    assign item_stall = !en;

    psd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .item_valid (item_valid),
        .item       (item),
        .q          (dchain[0])
    );

    // Divider row: the squared distance inside the segment is |v x w|^2 / |v|^2,
    // and at an endpoint the squared length divided by one.
    for (genvar g = 0; g < QW; g++)
    begin : g_div
        psd_div_cell #(
            .STEP (QW - 1 - g)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .d     (dchain[g]),
            .q     (dchain[g+1])
        );
    end

    always_comb
    begin
        schain[0].valid = dchain[QW].valid;
        schain[0].side  = dchain[QW].side;
        schain[0].rad   = dchain[QW].quo;
        schain[0].rem   = '0;
        schain[0].root  = '0;
    end

    // Square root row, most significant root bit first.
    for (genvar g = 0; g < RW; g++)
    begin : g_sqrt
        psd_sqrt_cell #(
            .STEP (RW - 1 - g)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .d     (schain[g]),
            .q     (schain[g+1])
        );
    end

    // A flagged word reports a saturated distance.
    always_comb
    begin
        result_next.region   = schain[RW].side.region;
        result_next.outside  = schain[RW].side.outside;
        result_next.dist_res = schain[RW].side.outside ? '1 : schain[RW].root;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            result_valid_reg <= schain[RW].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A flagged word always carries the saturated distance.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.outside) |-> (result.dist_res == '1))
        else $error("flagged word without saturated distance");

    // Only a projection outside the segment can be flagged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.outside) |-> (result.region != REGION_INSIDE))
        else $error("inside projection flagged as outside");

    // With the output register empty the pipeline never holds off input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !item_stall)
        else $error("input stalled while output register is empty");

endmodule

`default_nettype wire
